>>> rtl/utf8v_pkg.sv
// ============================================================================
// utf8v_pkg : shared constants for the UTF-8 string validator
// Byte classes, continuation tag, terminator, code point bounds, sequence widths and decoder state.
// ============================================================================
package utf8v_pkg;

    // Lead byte classes
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;

    // Continuation byte form 10xxxxxx
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;

    // Terminator and count saturation
    localparam logic [7:0] NUL_BYTE   = 8'h00;
    localparam logic [7:0] COUNT_MAX  = 8'hFF;

    // Code point bounds
    localparam int         CP_W       = 21;
    localparam logic [CP_W-1:0] CP_MIN3  = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4  = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_MIN = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_MAX = 21'h00DFFF;

    // Sequence widths
    localparam logic [2:0] SEQ_NONE   = 3'd0;
    localparam logic [2:0] SEQ_W1     = 3'd1;
    localparam logic [2:0] SEQ_W2     = 3'd2;
    localparam logic [2:0] SEQ_W3     = 3'd3;
    localparam logic [2:0] SEQ_W4     = 3'd4;

    // Decoder state carried between bytes of one string
    typedef struct packed {
        logic [1:0]      pending_count;
        logic [2:0]      sequence_width;
        logic [CP_W-1:0] partial_codepoint;
        logic [7:0]      byte_count;
        logic            error_seen;
    } dec_state_t;

endpackage

>>> rtl/utf8_string_validator_top.sv
// ============================================================================
// utf8_string_validator_top : UTF-8 string validator, one byte per clock when not stalled
// Checks a NUL-terminated string for well-formed UTF-8 and a length limit,
// and gives one verdict with the text length once the last byte is processed.
// ============================================================================
// The block accepts one byte per clock while in_stall is low. Each accepted byte
// lands in an input register and is decoded from it against the
// running decoder state; the verdict for a string is loaded into the result
// register when its terminator is processed from the input register. Only
// a terminator can be held back: it waits in the input register while a
// previous verdict sits unconsumed in the result register, and in_stall
// rises until it moves.
// The limit register applies min(max_text_bytes, LENGTH_LIMIT - 1) text bytes.
module utf8_string_validator_top
    import utf8v_pkg::*;
#(
    parameter int LENGTH_LIMIT = 255
)
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       last_byte,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_valid,
    output logic [7:0] text_length
);

    localparam int LIMIT_W = $clog2(LENGTH_LIMIT);
    localparam int CMP_W   = (LIMIT_W > 8) ? LIMIT_W : 8;
    localparam logic [CMP_W-1:0] HARD_LIMIT = CMP_W'(LENGTH_LIMIT - 1);

    logic [7:0]      max_text_bytes_reg;
    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    logic            in_last_reg;
    dec_state_t      state_reg, state_next;
    logic            out_valid_reg;
    logic            is_valid_reg, is_valid_next;
    logic [7:0]      text_length_reg;

    logic            out_free;
    logic            proc_fire;
    logic            in_take;
    logic [CMP_W-1:0] cfg_ext;
    logic [CMP_W-1:0] eff_limit;
    logic [CP_W-1:0] cp_new;

    // Decide when the held transaction can be processed
    assign out_free  = !out_valid_reg || !out_stall;
    assign proc_fire = in_valid_reg && (!in_last_reg || out_free);
    assign in_stall  = in_valid_reg && !proc_fire;
    assign in_take   = in_valid && !in_stall;

    // Clamp the configured limit to the hard bound
    assign cfg_ext   = CMP_W'(max_text_bytes_reg);
    assign eff_limit = (cfg_ext < HARD_LIMIT) ? cfg_ext : HARD_LIMIT;

    // Extend the code point with the continuation payload
    assign cp_new = {state_reg.partial_codepoint[CP_W-7:0], in_byte_reg[5:0]};

    // Write the limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_text_bytes_reg <= 8'd128;
        else if (cfg_we)
            max_text_bytes_reg <= cfg_wdata;
    end

    // Capture the input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= in_valid;
        else if (proc_fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= text_byte;
            in_last_reg <= last_byte;
        end
    end

    // Decode one byte against the running state
    always_comb
    begin
        state_next    = state_reg;
        is_valid_next = 1'b0;
        if (in_last_reg)
        begin
            is_valid_next = !state_reg.error_seen && (in_byte_reg == NUL_BYTE)
                            && (state_reg.pending_count == 2'd0);
            state_next = '0;
        end
        else
        begin
            if (CMP_W'(state_reg.byte_count) >= eff_limit)
                state_next.error_seen = 1'b1;
            if (state_reg.byte_count != COUNT_MAX)
                state_next.byte_count = state_reg.byte_count + 8'd1;

            if (state_reg.pending_count != 2'd0)
            begin
                if ((in_byte_reg & CONT_MASK) != CONT_TAG)
                begin
                    // bad continuation: drop the sequence
                    state_next.error_seen    = 1'b1;
                    state_next.pending_count = 2'd0;
                end
                else
                begin
                    state_next.partial_codepoint = cp_new;
                    state_next.pending_count     = state_reg.pending_count - 2'd1;
                    if (state_reg.pending_count == 2'd1)
                    begin
                        if (((state_reg.sequence_width == SEQ_W3) && (cp_new < CP_MIN3))
                            || ((state_reg.sequence_width == SEQ_W4) && (cp_new < CP_MIN4))
                            || (cp_new > CP_MAX)
                            || ((cp_new >= SURR_MIN) && (cp_new <= SURR_MAX)))
                            state_next.error_seen = 1'b1;
                    end
                end
            end
            else if (in_byte_reg <= ASCII_MAX)
            begin
                if (in_byte_reg == NUL_BYTE)
                    state_next.error_seen = 1'b1;
                state_next.sequence_width    = SEQ_W1;
                state_next.partial_codepoint = CP_W'(in_byte_reg);
            end
            else if (in_byte_reg inside {[LEAD2_MIN:LEAD2_MAX]})
            begin
                state_next.partial_codepoint = CP_W'(in_byte_reg[4:0]);
                state_next.sequence_width    = SEQ_W2;
                state_next.pending_count     = 2'd1;
            end
            else if (in_byte_reg inside {[LEAD3_MIN:LEAD3_MAX]})
            begin
                state_next.partial_codepoint = CP_W'(in_byte_reg[3:0]);
                state_next.sequence_width    = SEQ_W3;
                state_next.pending_count     = 2'd2;
            end
            else if (in_byte_reg inside {[LEAD4_MIN:LEAD4_MAX]})
            begin
                state_next.partial_codepoint = CP_W'(in_byte_reg[2:0]);
                state_next.sequence_width    = SEQ_W4;
                state_next.pending_count     = 2'd3;
            end
            else
            begin
                state_next.error_seen = 1'b1;
            end
        end
    end

    // Advance the decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (proc_fire)
            state_reg <= state_next;
    end

    // Hold the verdict until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc_fire && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_last_reg)
        begin
            is_valid_reg    <= is_valid_next;
            text_length_reg <= state_reg.byte_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign is_valid    = is_valid_reg;
    assign text_length = text_length_reg;

endmodule

>>> rtl/utf8v_checker.sv
// ============================================================================
// utf8v_checker : port-level checks for the UTF-8 string validator
// Watches the handshakes and verdicts at the top level and binds to it.
// ============================================================================
module utf8v_checker #(
    parameter int LENGTH_LIMIT = 255
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       is_valid,
    input logic [7:0] text_length
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(is_valid)
                                   && $stable(text_length))
        else $error("result changed while stalled");

    // Back-pressure only while a verdict waits downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a waiting result");

    // A passing string never exceeds the hard length bound
    a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_valid |-> (32'(text_length) < LENGTH_LIMIT))
        else $error("valid verdict with text length beyond the bound");

    // Stall clears once the consumer frees the result register
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall)
        else $error("input stall held after result drained");

endmodule

bind utf8_string_validator_top utf8v_checker #(.LENGTH_LIMIT(LENGTH_LIMIT)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .is_valid    (is_valid),
    .text_length (text_length)
);
